[rtl/msq_pkg.sv]
// Shared types, codes, scale tables and helper functions of the scale quantizer
`timescale 1ns / 1ps

package msq_pkg;

    // field widths
    localparam int REQ_W   = 2;
    localparam int NOTE_W  = 9;
    localparam int STEPS_W = 8;
    localparam int RES_W   = 7;
    localparam int MODE_W  = 5;
    localparam int ROOT_W  = 4;
    localparam int MASK_W  = 12;
    localparam int PC_W    = 4;   // pitch class, 0..11
    localparam int CIDX_W  = 2;   // config register index
    localparam int CDATA_W = 12;  // config write data
    localparam int UPC_W   = 4;   // microcode address

    localparam logic [RES_W-1:0]  NOTE_TOP   = 7'd127;
    localparam logic [PC_W-1:0]   PC_LAST    = 4'd11;
    localparam logic [PC_W-1:0]   SEMIS      = 4'd12;
    localparam logic [MODE_W-1:0] MODE_CUSTOM = 5'd16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TEST  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUANT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TRANS = 2'd2;

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ROOT   = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CUSTOM = 2'd2;

    // built-in mode masks, bit i = pitch class i
    localparam logic [MASK_W-1:0] MODE_MASKS [16] = '{
        12'hAB5, 12'h5AD, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h56B, 12'h9AD,
        12'hAAD, 12'h295, 12'h4A9, 12'h4E9, 12'h555, 12'h6DB, 12'h999, 12'hFFF
    };

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1,
        OP_STEP   = 3'd2,
        OP_TRY_UP = 3'd3,
        OP_TRY_DN = 3'd4,
        OP_WALK   = 3'd5,
        OP_EMIT   = 3'd6
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER     = 4'd0,
        C_ALWAYS    = 4'd1,
        C_NO_ACC    = 4'd2,
        C_IS_Q      = 4'd3,
        C_IS_T      = 4'd4,
        C_C_HIT     = 4'd5,
        C_D_DONE    = 4'd6,
        C_UP_HIT    = 4'd7,
        C_DN_HIT    = 4'd8,
        C_LEFT_ZERO = 4'd9,
        C_WALK_MORE = 4'd10,
        C_OUT_FREE  = 4'd11
    } t_cond;

    // one control word
    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] tgt;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic accept;
        logic is_q;
        logic is_t;
        logic c_hit;
        logic d_done;
        logic up_hit;
        logic dn_hit;
        logic left_zero;
        logic walk_more;
        logic out_free;
    } t_status;

    // pitch class of a 7-bit note by four conditional subtracts
    function automatic logic [PC_W-1:0] pc_of(input logic [RES_W-1:0] n);
        logic [RES_W-1:0] v;
        v = n;
        if (v >= 7'd96) v = v - 7'd96;
        if (v >= 7'd48) v = v - 7'd48;
        if (v >= 7'd24) v = v - 7'd24;
        if (v >= 7'd12) v = v - 7'd12;
        return v[PC_W-1:0];
    endfunction

    // scale mask from mode, root and custom mask
    function automatic logic [MASK_W-1:0] active_mask(
        input logic [MODE_W-1:0] mode,
        input logic [ROOT_W-1:0] root,
        input logic [MASK_W-1:0] custom
    );
        logic [ROOT_W-1:0]   r;
        logic [MASK_W-1:0]   m;
        logic [2*MASK_W-1:0] dbl;
        r   = (root >= SEMIS) ? root - SEMIS : root;
        m   = MODE_MASKS[mode[3:0]];
        dbl = {m, m} << r;
        if (mode == MODE_CUSTOM) return custom;
        else if (mode[4]) return '0;
        else return dbl[2*MASK_W-1:MASK_W];
    endfunction

endpackage

[rtl/msq_if.sv]
// Handshake channel interfaces of the scale quantizer
`timescale 1ns / 1ps

// request item channel
interface msq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [msq_pkg::REQ_W-1:0]            req_type;
    logic signed [msq_pkg::NOTE_W-1:0]    note;
    logic signed [msq_pkg::STEPS_W-1:0]   degree_steps;
    modport source (output valid, req_type, note, degree_steps, input ready);
    modport sink   (input valid, req_type, note, degree_steps, output ready);
endinterface

// result item channel
interface msq_out_if;
    logic                       valid;
    logic                       ready;
    logic [msq_pkg::RES_W-1:0]  result_note;
    logic                       in_scale;
    modport source (output valid, result_note, in_scale, input ready);
    modport sink   (input valid, result_note, in_scale, output ready);
endinterface

// configuration write channel
interface msq_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [msq_pkg::CIDX_W-1:0]   index;
    logic [msq_pkg::CDATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/msq_seq.sv]
// Microcode sequencer: program table, step counter and conditional jumps
`timescale 1ns / 1ps

module msq_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  msq_pkg::t_status i_stat,
    output msq_pkg::t_op     o_op
);

    localparam logic [msq_pkg::UPC_W-1:0] A_IDLE  = 4'd0;
    localparam logic [msq_pkg::UPC_W-1:0] A_QUANT = 4'd4;
    localparam logic [msq_pkg::UPC_W-1:0] A_QSTEP = 4'd5;
    localparam logic [msq_pkg::UPC_W-1:0] A_TRANS = 4'd9;
    localparam logic [msq_pkg::UPC_W-1:0] A_WALK  = 4'd10;
    localparam logic [msq_pkg::UPC_W-1:0] A_EMIT  = 4'd11;
    localparam logic [msq_pkg::UPC_W-1:0] A_HOLD  = 4'd12;

    logic [msq_pkg::UPC_W-1:0] r_pc;
    logic [msq_pkg::UPC_W-1:0] n_pc;
    msq_pkg::t_uword           w_word;
    logic                      w_take;

    // program table
    function automatic msq_pkg::t_uword prog(input logic [msq_pkg::UPC_W-1:0] a);
        msq_pkg::t_uword w;
        case (a)
            4'd0:  w = '{msq_pkg::OP_LOAD,   msq_pkg::C_NO_ACC,    A_IDLE};
            4'd1:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_IS_Q,      A_QUANT};
            4'd2:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_IS_T,      A_TRANS};
            4'd3:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_ALWAYS,    A_EMIT};
            4'd4:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_C_HIT,     A_EMIT};
            4'd5:  w = '{msq_pkg::OP_STEP,   msq_pkg::C_D_DONE,    A_EMIT};
            4'd6:  w = '{msq_pkg::OP_TRY_UP, msq_pkg::C_UP_HIT,    A_EMIT};
            4'd7:  w = '{msq_pkg::OP_TRY_DN, msq_pkg::C_DN_HIT,    A_EMIT};
            4'd8:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_ALWAYS,    A_QSTEP};
            4'd9:  w = '{msq_pkg::OP_NONE,   msq_pkg::C_LEFT_ZERO, A_EMIT};
            4'd10: w = '{msq_pkg::OP_WALK,   msq_pkg::C_WALK_MORE, A_WALK};
            4'd11: w = '{msq_pkg::OP_EMIT,   msq_pkg::C_OUT_FREE,  A_IDLE};
            4'd12: w = '{msq_pkg::OP_NONE,   msq_pkg::C_ALWAYS,    A_EMIT};
            default: w = '{msq_pkg::OP_NONE, msq_pkg::C_ALWAYS,    A_IDLE};
        endcase
        return w;
    endfunction

    assign w_word = prog(r_pc);
    assign o_op   = w_word.op;

    // condition select
    always_comb begin
        case (w_word.cond)
            msq_pkg::C_NEVER:     w_take = 1'b0;
            msq_pkg::C_ALWAYS:    w_take = 1'b1;
            msq_pkg::C_NO_ACC:    w_take = !i_stat.accept;
            msq_pkg::C_IS_Q:      w_take = i_stat.is_q;
            msq_pkg::C_IS_T:      w_take = i_stat.is_t;
            msq_pkg::C_C_HIT:     w_take = i_stat.c_hit;
            msq_pkg::C_D_DONE:    w_take = i_stat.d_done;
            msq_pkg::C_UP_HIT:    w_take = i_stat.up_hit;
            msq_pkg::C_DN_HIT:    w_take = i_stat.dn_hit;
            msq_pkg::C_LEFT_ZERO: w_take = i_stat.left_zero;
            msq_pkg::C_WALK_MORE: w_take = i_stat.walk_more;
            msq_pkg::C_OUT_FREE:  w_take = i_stat.out_free;
            default:              w_take = 1'b0;
        endcase
    end

    assign n_pc = w_take ? w_word.tgt : r_pc + 4'd1;

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // loading happens only at the idle step
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == msq_pkg::OP_LOAD) |-> (r_pc == A_IDLE))
        else $error("load op away from idle step");

    // an accepted item always leaves the idle step
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == msq_pkg::OP_LOAD && i_stat.accept) |=> (r_pc != A_IDLE))
        else $error("sequencer stayed idle after accept");

    // the step counter stays inside the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= A_HOLD)
        else $error("step counter outside the program");

endmodule

[rtl/musical_scale_quantizer_unit.sv]
// Top level of the scale quantizer: config registers, datapath and result register
// The block takes one item at a time: a new item is accepted only at the idle step, after the
// last result has gone into the result register. A full result register stalls the emit step,
// which retries through the hold step until the result slot is free.
// Reset (synchronous, active low) clears the config registers to C major and empties the result slot.
`timescale 1ns / 1ps

module musical_scale_quantizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msq_in_if.sink      i_item,
    msq_out_if.source   o_result,
    msq_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [msq_pkg::MODE_W-1:0] r_mode;
    logic [msq_pkg::ROOT_W-1:0] r_root;
    logic [msq_pkg::MASK_W-1:0] r_custom;

    // datapath registers
    logic [msq_pkg::REQ_W-1:0]   r_req;
    logic [msq_pkg::MASK_W-1:0]  r_mask;
    logic                        r_member;
    logic [msq_pkg::RES_W-1:0]   r_res;
    logic [msq_pkg::RES_W:0]     r_up;
    logic [msq_pkg::PC_W-1:0]    r_upc;
    logic signed [msq_pkg::RES_W:0] r_dn;
    logic [msq_pkg::PC_W-1:0]    r_dnc;
    logic [msq_pkg::PC_W-1:0]    r_d;
    logic [msq_pkg::RES_W-1:0]   r_cur;
    logic [msq_pkg::PC_W-1:0]    r_wpc;
    logic [msq_pkg::STEPS_W-1:0] r_left;
    logic                        r_dir_dn;

    // result register
    logic                        r_out_valid;
    logic [msq_pkg::RES_W-1:0]   r_out_note;
    logic                        r_out_in_scale;

    msq_pkg::t_op                w_op;
    msq_pkg::t_status            w_stat;
    logic                        w_accept;
    logic                        w_out_free;
    logic [msq_pkg::RES_W-1:0]   w_clamp;
    logic [msq_pkg::PC_W-1:0]    w_cpc;
    logic [msq_pkg::MASK_W-1:0]  w_mask;
    logic [msq_pkg::STEPS_W-1:0] w_abs;
    logic [msq_pkg::RES_W-1:0]   n_cur;
    logic [msq_pkg::PC_W-1:0]    n_wpc;
    logic [msq_pkg::STEPS_W-1:0] n_left;
    logic                        w_walk_hit;

    // sequencer
    msq_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // handshakes
    assign i_item.ready  = i_rst_n && (w_op == msq_pkg::OP_LOAD);
    assign w_accept      = i_item.valid && i_item.ready;
    assign w_out_free    = !r_out_valid || o_result.ready;
    assign i_cfg.ready   = i_rst_n;

    assign o_result.valid       = r_out_valid;
    assign o_result.result_note = r_out_note;
    assign o_result.in_scale    = r_out_in_scale;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_root   <= '0;
            r_custom <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                msq_pkg::CFG_MODE:   r_mode   <= i_cfg.data[msq_pkg::MODE_W-1:0];
                msq_pkg::CFG_ROOT:   r_root   <= i_cfg.data[msq_pkg::ROOT_W-1:0];
                msq_pkg::CFG_CUSTOM: r_custom <= i_cfg.data[msq_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // input note clamp, pitch class and step magnitude
    always_comb begin
        if (i_item.note[msq_pkg::NOTE_W-1]) w_clamp = '0;
        else if (i_item.note[msq_pkg::NOTE_W-2]) w_clamp = msq_pkg::NOTE_TOP;
        else w_clamp = i_item.note[msq_pkg::RES_W-1:0];
    end
    assign w_cpc  = msq_pkg::pc_of(w_clamp);
    assign w_mask = msq_pkg::active_mask(r_mode, r_root, r_custom);
    assign w_abs  = i_item.degree_steps[msq_pkg::STEPS_W-1]
                  ? 8'd0 - i_item.degree_steps : i_item.degree_steps;

    // one semitone of the transpose walk, clamped at both ends
    always_comb begin
        n_cur = r_cur;
        n_wpc = r_wpc;
        if (r_dir_dn) begin
            if (r_cur != '0) begin
                n_cur = r_cur - 7'd1;
                n_wpc = (r_wpc == '0) ? msq_pkg::PC_LAST : r_wpc - 4'd1;
            end
        end else begin
            if (r_cur != msq_pkg::NOTE_TOP) begin
                n_cur = r_cur + 7'd1;
                n_wpc = (r_wpc == msq_pkg::PC_LAST) ? '0 : r_wpc + 4'd1;
            end
        end
    end
    assign w_walk_hit = r_mask[n_wpc];
    assign n_left     = r_left - {7'd0, w_walk_hit};

    // flags for the sequencer
    assign w_stat.accept    = w_accept;
    assign w_stat.is_q      = (r_req == msq_pkg::REQ_QUANT);
    assign w_stat.is_t      = (r_req == msq_pkg::REQ_TRANS);
    assign w_stat.c_hit     = r_mask[r_upc];  // before the first step r_upc is the note's class
    assign w_stat.d_done    = (r_d == msq_pkg::SEMIS);
    assign w_stat.up_hit    = !r_up[msq_pkg::RES_W] && r_mask[r_upc];
    assign w_stat.dn_hit    = !r_dn[msq_pkg::RES_W] && r_mask[r_dnc];
    assign w_stat.left_zero = (r_left == '0);
    assign w_stat.walk_more = (n_left != '0) && (n_cur != '0) && (n_cur != msq_pkg::NOTE_TOP);
    assign w_stat.out_free  = w_out_free;

    // datapath
    always_ff @(posedge i_clk) begin
        case (w_op)
            msq_pkg::OP_LOAD: begin
                if (w_accept) begin
                    r_req    <= i_item.req_type;
                    r_mask   <= w_mask;
                    r_member <= !i_item.note[msq_pkg::NOTE_W-1]
                             && !i_item.note[msq_pkg::NOTE_W-2] && w_mask[w_cpc];
                    r_res    <= w_clamp;
                    r_up     <= {1'b0, w_clamp};
                    r_upc    <= w_cpc;
                    r_dn     <= {1'b0, w_clamp};
                    r_dnc    <= w_cpc;
                    r_cur    <= w_clamp;
                    r_wpc    <= w_cpc;
                    r_left   <= w_abs;
                    r_dir_dn <= i_item.degree_steps[msq_pkg::STEPS_W-1];
                end
            end
            msq_pkg::OP_STEP: begin
                if (!w_stat.d_done) begin
                    r_up  <= r_up + 8'd1;
                    r_upc <= (r_upc == msq_pkg::PC_LAST) ? '0 : r_upc + 4'd1;
                    r_dn  <= r_dn - 8'sd1;
                    r_dnc <= (r_dnc == '0) ? msq_pkg::PC_LAST : r_dnc - 4'd1;
                end
            end
            msq_pkg::OP_TRY_UP: begin
                if (w_stat.up_hit) r_res <= r_up[msq_pkg::RES_W-1:0];
            end
            msq_pkg::OP_TRY_DN: begin
                if (w_stat.dn_hit) r_res <= r_dn[msq_pkg::RES_W-1:0];
            end
            msq_pkg::OP_WALK: begin
                r_cur  <= n_cur;
                r_wpc  <= n_wpc;
                r_left <= n_left;
                r_res  <= n_cur;
            end
            default: ;
        endcase
    end

    // distance counter, cleared on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (w_op == msq_pkg::OP_LOAD && w_accept) begin
            r_d <= '0;
        end else if (w_op == msq_pkg::OP_STEP && !w_stat.d_done) begin
            r_d <= r_d + 4'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op == msq_pkg::OP_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == msq_pkg::OP_EMIT && w_out_free) begin
            r_out_note     <= r_res;
            r_out_in_scale <= r_member;
        end
    end

    // quantize search never goes past one octave
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d <= msq_pkg::SEMIS)
        else $error("quantize distance beyond one octave");

    // the walk only runs with degrees left
    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == msq_pkg::OP_WALK) |-> (r_left != '0))
        else $error("transpose walk with no degrees left");

    // a new result appears only from the emit step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_op == msq_pkg::OP_EMIT))
        else $error("result valid without emit step");

    // walk pitch class stays a real class
    a_wpc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_op == msq_pkg::OP_WALK) |-> (r_wpc <= msq_pkg::PC_LAST))
        else $error("walk pitch class out of range");

endmodule

[sim/musical_scale_quantizer_unit_tb.sv]
// Self-checking testbench of the scale quantizer: directed requests, random scales and back-pressure
`timescale 1ns / 1ps

module musical_scale_quantizer_unit_tb;

    typedef logic [msq_pkg::REQ_W-1:0]          t_req;
    typedef logic signed [msq_pkg::NOTE_W-1:0]  t_note;
    typedef logic signed [msq_pkg::STEPS_W-1:0] t_steps;
    typedef logic [msq_pkg::MODE_W-1:0]         t_mode;
    typedef logic [msq_pkg::ROOT_W-1:0]         t_root;
    typedef logic [msq_pkg::MASK_W-1:0]         t_mask;
    typedef logic [msq_pkg::CDATA_W-1:0]        t_cdata;

    localparam t_req REQ_SPARE = 2'd3;   // decoded as a membership test
    localparam logic [msq_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;   // index with no register behind it
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASE_ITEMS   = 100;
    localparam int PHASES        = 16;

    // one result item as the block should return it
    typedef struct packed {
        logic [msq_pkg::RES_W-1:0] note;
        logic                      member;
    } t_note_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    msq_in_if  item_if ();
    msq_out_if res_if ();
    msq_cfg_if cfg_if ();

    musical_scale_quantizer_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    // scale settings as the block should hold them
    t_mode cur_mode   = '0;
    t_root cur_root   = '0;
    t_mask cur_custom = '0;

    t_note_result expected_notes [$];
    int  fail_count   = 0;
    bit  idle_on      = 1'b1;
    bit  hold_results = 1'b0;

    // clock
    always #HALF_PERIOD i_clk = ~i_clk;

    // run limit
    initial begin
        #50_000_000;
        $display("musical_scale_quantizer_unit test failed");
        $finish;
    end

    // gap length: mostly none or short, a few long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (!idle_on || pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pitch-class set of the current scale
    function automatic t_mask scale_pitch_set();
        int base;
        int shift;
        if (cur_mode == msq_pkg::MODE_CUSTOM) return cur_custom;
        if (cur_mode > 5'd15) return '0;
        base  = msq_pkg::MODE_MASKS[cur_mode[3:0]];
        shift = cur_root % 12;
        return t_mask'(((base << shift) | (base >> (12 - shift))) & 12'hFFF);
    endfunction

    // expected result of one request under the current scale
    function automatic t_note_result scale_response(
        input t_req   req,
        input t_note  note,
        input t_steps steps
    );
        t_mask        pcs;
        t_note_result r;
        int n;
        int s;
        int c;
        int outn;
        int d;
        int dir;
        int left;
        int cur;
        pcs  = scale_pitch_set();
        n    = note;
        s    = steps;
        c    = (n < 0) ? 0 : (n > 127) ? 127 : n;
        outn = c;
        r.member = (n >= 0 && n <= 127) ? pcs[n % 12] : 1'b0;
        if (req == msq_pkg::REQ_QUANT) begin
            // nearest scale note, upward candidate first at each distance
            if (!pcs[c % 12]) begin
                for (d = 1; d <= 12; d++) begin
                    if (c + d <= 127 && pcs[(c + d) % 12]) begin
                        outn = c + d;
                        break;
                    end
                    if (c - d >= 0 && pcs[(c - d) % 12]) begin
                        outn = c - d;
                        break;
                    end
                end
            end
        end else if (req == msq_pkg::REQ_TRANS && s != 0) begin
            // semitone walk, one degree per scale note reached, stop at the range edges
            dir  = (s > 0) ? 1 : -1;
            left = (s > 0) ? s : -s;
            cur  = c;
            while (left > 0) begin
                cur = cur + dir;
                if (cur < 0) cur = 0;
                if (cur > 127) cur = 127;
                if (pcs[cur % 12]) left--;
                if (cur == 0 || cur == 127) break;
            end
            outn = cur;
        end
        r.note = outn[msq_pkg::RES_W-1:0];
        return r;
    endfunction

    // offer one request item and record its expected result once accepted
    task automatic send_item(
        input t_req   req,
        input t_note  note,
        input t_steps steps
    );
        int gap;
        item_if.valid        <= 1'b1;
        item_if.req_type     <= req;
        item_if.note         <= note;
        item_if.degree_steps <= steps;
        do @(posedge i_clk); while (!item_if.ready);
        expected_notes.insert(expected_notes.size(), scale_response(req, note, steps));
        gap = idle_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_done();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_notes.size() != 0);
    endtask

    // write all scale registers plus the spare index, with junk in the unused data bits
    task automatic set_scale(
        input t_mode mode,
        input t_root root,
        input t_mask mask
    );
        logic [msq_pkg::CIDX_W-1:0] idx   [4];
        t_cdata                     words [4];
        idx      = '{msq_pkg::CFG_MODE, msq_pkg::CFG_ROOT, msq_pkg::CFG_CUSTOM, CFG_UNUSED};
        words[0] = t_cdata'({$urandom, mode});
        words[1] = t_cdata'({$urandom, root});
        words[2] = mask;
        words[3] = t_cdata'($urandom);
        for (int i = 0; i < 4; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= words[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        cur_mode   = mode;
        cur_root   = root;
        cur_custom = mask;
    endtask

    // membership test in the reset scale, out-of-range notes and the spare request code
    task automatic test_membership();
        send_item(msq_pkg::REQ_TEST, -9'sd256, 8'sd0);
        send_item(msq_pkg::REQ_TEST, -9'sd1, 8'sd0);
        send_item(msq_pkg::REQ_TEST, 9'sd0, -8'sd128);
        send_item(msq_pkg::REQ_TEST, 9'sd61, 8'sd127);
        send_item(msq_pkg::REQ_TEST, 9'sd127, 8'sd0);
        send_item(msq_pkg::REQ_TEST, 9'sd128, 8'sd0);
        send_item(msq_pkg::REQ_TEST, 9'sd255, -8'sd1);
        send_item(REQ_SPARE, 9'sd64, 8'sd5);
    endtask

    // quantize: clamping, upward preference on a tie, far search and an empty scale
    task automatic test_quantize();
        send_item(msq_pkg::REQ_QUANT, 9'sd1, 8'sd0);
        send_item(msq_pkg::REQ_QUANT, -9'sd7, 8'sd0);
        send_item(msq_pkg::REQ_QUANT, 9'sd126, 8'sd0);
        send_item(msq_pkg::REQ_QUANT, 9'sd255, 8'sd0);
        wait_results_done();
        set_scale(msq_pkg::MODE_CUSTOM, 4'd0, 12'h001);
        send_item(msq_pkg::REQ_QUANT, 9'sd127, 8'sd0);
        send_item(msq_pkg::REQ_QUANT, 9'sd66, 8'sd0);
        send_item(msq_pkg::REQ_QUANT, 9'sd5, 8'sd0);
        wait_results_done();
        set_scale(5'd17, 4'd3, 12'hFFF);
        send_item(msq_pkg::REQ_QUANT, 9'sd61, 8'sd0);
    endtask

    // transpose: zero steps, full-range walks, edge stops and an empty scale
    task automatic test_transpose();
        wait_results_done();
        set_scale(5'd0, 4'd0, 12'h000);
        send_item(msq_pkg::REQ_TRANS, 9'sd0, 8'sd127);
        send_item(msq_pkg::REQ_TRANS, 9'sd127, -8'sd128);
        send_item(msq_pkg::REQ_TRANS, 9'sd60, 8'sd0);
        send_item(msq_pkg::REQ_TRANS, 9'sd60, 8'sd1);
        send_item(msq_pkg::REQ_TRANS, 9'sd60, -8'sd1);
        send_item(msq_pkg::REQ_TRANS, 9'sd125, 8'sd5);
        send_item(msq_pkg::REQ_TRANS, 9'sd2, -8'sd3);
        send_item(msq_pkg::REQ_TRANS, -9'sd5, 8'sd2);
        send_item(msq_pkg::REQ_TRANS, 9'sd200, -8'sd2);
        wait_results_done();
        set_scale(5'd31, 4'd15, 12'hFFF);
        send_item(msq_pkg::REQ_TRANS, 9'sd60, 8'sd3);
    endtask

    // random requests over a series of scales, extremes first
    task automatic test_random_scales();
        t_mode  mode;
        t_root  root;
        t_mask  mask;
        t_req   req;
        t_note  note;
        t_steps steps;
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_results_done();
            mode = ($urandom_range(0, 99) < 80) ? t_mode'($urandom_range(0, 16))
                                                : t_mode'($urandom_range(17, 31));
            root = t_root'($urandom_range(0, 15));
            mask = t_mask'($urandom);
            case (ph)
                0: begin mode = msq_pkg::MODE_CUSTOM; mask = 12'h000; end
                1: begin mode = msq_pkg::MODE_CUSTOM; mask = 12'hFFF; end
                2: begin mode = 5'd31; root = 4'd15; end
                3: begin mode = 5'd15; root = 4'd12; end
                4: begin mode = 5'd0; root = 4'd11; end
                5: begin mode = 5'd13; root = 4'd14; end
                default: ;
            endcase
            set_scale(mode, root, mask);
            // every other phase runs both sides at full rate
            idle_on = ph[0];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                req = ($urandom_range(0, 19) == 0) ? REQ_SPARE : t_req'($urandom_range(0, 2));
                note = ($urandom_range(0, 9) < 7) ? t_note'($urandom_range(0, 127))
                                                  : t_note'($urandom);
                steps = ($urandom_range(0, 9) < 7) ? t_steps'($urandom_range(0, 24) - 12)
                                                   : t_steps'($urandom);
                send_item(req, note, steps);
            end
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        wait_results_done();
        set_scale(5'd4, 4'd7, 12'h000);
        idle_on      = 1'b0;
        hold_results = 1'b1;
        for (int k = 0; k < 16; k++) begin
            send_item(k[0] ? msq_pkg::REQ_TRANS : msq_pkg::REQ_QUANT,
                      t_note'($urandom_range(0, 127)),
                      t_steps'($urandom_range(0, 40) - 20));
        end
        wait_results_done();
        idle_on = 1'b1;
    endtask

    // result ready with random gaps and the occasional long hold
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_results) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                if (idle_on) begin
                    int gap;
                    gap = idle_len();
                    if (gap > 0) begin
                        res_if.ready <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_note_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_notes.size() == 0) begin
                $error("result item with no request pending: result_note %0d in_scale %0b",
                       res_if.result_note, res_if.in_scale);
                fail_count++;
            end else begin
                want = expected_notes.pop_front();
                if (res_if.result_note !== want.note) begin
                    $error("result_note mismatch: expected %0d, actual %0d",
                           want.note, res_if.result_note);
                    fail_count++;
                end
                if (res_if.in_scale !== want.member) begin
                    $error("in_scale mismatch: expected %0b, actual %0b",
                           want.member, res_if.in_scale);
                    fail_count++;
                end
            end
        end
    end

    // reset, test sequence and final verdict
    initial begin
        item_if.valid        = 1'b0;
        item_if.req_type     = msq_pkg::REQ_TEST;
        item_if.note         = '0;
        item_if.degree_steps = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = msq_pkg::CFG_MODE;
        cfg_if.data          = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_membership();
        test_quantize();
        test_transpose();
        test_random_scales();
        test_backpressure();

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("musical_scale_quantizer_unit test passed");
        end else begin
            $display("musical_scale_quantizer_unit test failed");
        end
        $finish;
    end

endmodule
